>>> design/ir_beacon_servo_seeker_core_macros.svh
// Assertion macros for the IR beacon seeker core.
// Active in simulation; empty when SYNTH is defined.
`ifndef IR_BEACON_SERVO_SEEKER_CORE_MACROS_SVH
`define IR_BEACON_SERVO_SEEKER_CORE_MACROS_SVH

`ifndef SYNTH
`define IBSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ibss assertion failed");
`define IBSS_ASSERT_NOT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) not (prop)) \
    else $error("ibss assertion failed");
`else
`define IBSS_ASSERT(lbl, prop)
`define IBSS_ASSERT_NOT(lbl, prop)
`endif

`endif

>>> design/ibss_pkg.sv
// Shared types, register indexes and the servo code function of the seeker core.
// No dependencies.
package ibss_pkg;

  localparam int unsigned PeriodW  = 20;
  localparam int unsigned StepW    = 6;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned ReadingW = 4;
  localparam int unsigned CfgAddrW = 1;

  localparam logic [CfgAddrW-1:0] REG_UPDATE_PERIOD = 1'b0;
  localparam logic [CfgAddrW-1:0] REG_STEP_DEGREES  = 1'b1;

  localparam logic [PeriodW-1:0]  PERIOD_RESET   = 20'd10000;
  localparam logic [StepW-1:0]    STEP_RESET     = 6'd3;
  localparam logic [ReadingW-1:0] READING_NONE   = 4'd0;
  localparam logic [ReadingW-1:0] READING_CENTER = 4'd5;

  typedef enum logic [1:0] {
    TRACK_NONE  = 2'd0,
    TRACK_LEFT  = 2'd1,
    TRACK_RIGHT = 2'd2,
    TRACK_LOCK  = 2'd3
  } track_e;

  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [StepW-1:0]   step;
  } cfg_t;

  typedef struct packed {
    track_e             track;
    logic signed [7:0]  angle;
    logic [7:0]         servo;
  } res_t;

  // x * 255 / 180 == x * 17 / 12; divide by 4 by shift, then by 3 via 683 / 2048
  function automatic logic [7:0] servo_code(input logic [7:0] x);
    logic [11:0] n;
    logic [19:0] p;
    n = 12'(x) * 12'd17;
    p = 20'(n[11:2]) * 20'd683;
    return p[18:11];
  endfunction

endpackage

>>> design/ibss_cfg_regs.sv
// Configuration registers of the seeker core: update period and step size.
// Depends on ibss_pkg.
module ibss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ibss_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ibss_pkg::PeriodW-1:0]  cfg_wdata_i,
  output ibss_pkg::cfg_t                cfg_o
);
  import ibss_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_UPDATE_PERIOD: cfg_d.period = cfg_wdata_i;
        REG_STEP_DEGREES:  cfg_d.step   = cfg_wdata_i[StepW-1:0];
        default:           cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= PERIOD_RESET;
      cfg_q.step   <= STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/ibss_update.sv
// Time accumulator, seek angle, sweep direction and tracking state of the seeker.
// Computes one item's update combinationally. Depends on ibss_pkg.
module ibss_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [ibss_pkg::ElapsedW-1:0] elapsed_i,
  input  logic [ibss_pkg::ReadingW-1:0] reading_i,
  input  ibss_pkg::cfg_t                cfg_i,
  output logic                          hit_o,
  output ibss_pkg::res_t                res_o
);
  import ibss_pkg::*;

  logic [PeriodW-1:0]  acc_q, acc_d;
  logic signed [7:0]   angle_q, angle_d;
  logic                scan_left_q, scan_left_d;
  track_e              track_q, track_d;

  logic [PeriodW:0]    sum;
  logic                hit;
  logic signed [8:0]   cur9;
  logic signed [8:0]   step9;
  logic signed [8:0]   moved;
  logic                scan_left_nx;
  logic signed [7:0]   angle_nx;
  logic [8:0]          diff9;
  track_e              track_nx;

  assign sum   = {1'b0, acc_q} + (PeriodW+1)'(elapsed_i);
  assign hit   = sum > {1'b0, cfg_i.period};
  assign cur9  = {angle_q[7], angle_q};
  assign step9 = {3'b000, cfg_i.step};

  always_comb begin
    moved        = cur9;
    scan_left_nx = scan_left_q;
    case (track_q)
      TRACK_NONE: begin
        moved = scan_left_q ? (cur9 + step9) : (cur9 - step9);
        if (!scan_left_q && (moved < -9'sd90)) begin
          scan_left_nx = 1'b1;
        end
        if (scan_left_nx && (moved > 9'sd90)) begin
          scan_left_nx = 1'b0;
        end
      end
      TRACK_LEFT: begin
        moved        = cur9 + step9;
        scan_left_nx = 1'b1;
      end
      TRACK_RIGHT: begin
        moved        = cur9 - step9;
        scan_left_nx = 1'b0;
      end
      default: begin
        moved = cur9;
      end
    endcase

    if (moved > 9'sd90) begin
      angle_nx = 8'sd90;
    end else if (moved < -9'sd90) begin
      angle_nx = -8'sd90;
    end else begin
      angle_nx = moved[7:0];
    end
  end

  assign diff9 = 9'd90 - {angle_nx[7], angle_nx};

  always_comb begin
    if (reading_i == READING_NONE) begin
      track_nx = TRACK_NONE;
    end else if (reading_i > READING_CENTER) begin
      track_nx = TRACK_LEFT;
    end else if (reading_i < READING_CENTER) begin
      track_nx = TRACK_RIGHT;
    end else begin
      track_nx = TRACK_LOCK;
    end
  end

  always_comb begin
    acc_d       = acc_q;
    angle_d     = angle_q;
    scan_left_d = scan_left_q;
    track_d     = track_q;
    if (fire_i) begin
      if (hit) begin
        acc_d       = '0;
        angle_d     = angle_nx;
        scan_left_d = scan_left_nx;
        track_d     = track_nx;
      end else begin
        acc_d = sum[PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      angle_q     <= '0;
      scan_left_q <= 1'b1;
      track_q     <= TRACK_NONE;
    end else begin
      acc_q       <= acc_d;
      angle_q     <= angle_d;
      scan_left_q <= scan_left_d;
      track_q     <= track_d;
    end
  end

  assign hit_o       = hit;
  assign res_o.servo = servo_code(diff9[7:0]);
  assign res_o.angle = angle_nx;
  assign res_o.track = track_nx;

endmodule

>>> design/ir_beacon_servo_seeker_core.sv
// Top level of the IR beacon seeker servo core: input register, update logic,
// result register. Depends on ibss_pkg, ibss_cfg_regs, ibss_update and the macros header.
//
//   channel  | dir | payload (lsb first)                          | handshake
//   s_axis   | in  | elapsed_us[15:0], sensor_reading[19:16]      | tvalid/tready
//   m_axis   | out | servo_position[7:0], angle[15:8], track[17:16] | tvalid/tready
//   cfg      | in  | 0 update_period_us, 1 step_degrees           | cfg_we_i
//
// One item per cycle unless m_axis stalls; path: input register, then result register.
// The update is a single pass from the input register through the angle step,
// clamp and servo code into the result register.
// Reset is asynchronous, active low; no clearing pass.
// A stalled m_axis holds the result; the input register still takes one more item.
`include "ir_beacon_servo_seeker_core_macros.svh"

module ir_beacon_servo_seeker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // elapsed_us, sensor_reading, pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // servo_position, angle_degrees,
                                                        // track_state, pad
  input  logic                          cfg_we_i,
  input  logic [ibss_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [ibss_pkg::PeriodW-1:0]  cfg_wdata_i
);
  import ibss_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [ReadingW-1:0] reading_q, reading_d;
  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  cfg_t                cfg;
  res_t                res;
  logic                hit;
  logic                fire;
  logic                s_acc;

  ibss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  ibss_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .elapsed_i(elapsed_q),
    .reading_i(reading_q),
    .cfg_i    (cfg),
    .hit_o    (hit),
    .res_o    (res)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    elapsed_d   = elapsed_q;
    reading_d   = reading_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (s_acc) begin
      in_valid_d = 1'b1;
      elapsed_d  = s_axis_tdata[ElapsedW-1:0];
      reading_d  = s_axis_tdata[ElapsedW +: ReadingW];
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (fire && hit) begin
      out_valid_d = 1'b1;
      res_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    reading_q <= reading_d;
    res_q     <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, res_q.track, res_q.angle, res_q.servo};

  `IBSS_ASSERT(a_angle_range, out_valid_q |-> (res_q.angle <= 8'sd90 && res_q.angle >= -8'sd90))
  `IBSS_ASSERT(a_servo_left_end, (out_valid_q && res_q.angle == 8'sd90) |-> (res_q.servo == 8'd0))
  `IBSS_ASSERT(a_servo_right_end, (out_valid_q && res_q.angle == -8'sd90) |-> (res_q.servo == 8'd255))
  `IBSS_ASSERT_NOT(a_ready_when_empty, !in_valid_q && !s_axis_tready)

endmodule

>>> test/ir_beacon_servo_seeker_core_tb.sv
// Self-checking testbench for ir_beacon_servo_seeker_core: random-gap item stream, random
// result stalls, register changes between phases, and an in-bench update predictor.
// Depends on ibss_pkg and the core RTL.
module ir_beacon_servo_seeker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ibss_pkg::*;

  localparam int PhaseItems = 170;
  localparam int MaxGap     = 18;
  localparam int HoldCycles = 300;

  typedef struct {
    logic [ElapsedW-1:0] elapsed;
    logic [ReadingW-1:0] reading;
    int                  gap;
  } seek_item_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;   // elapsed_us, sensor_reading, pad
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;         // servo_position, angle_degrees, track_state, pad
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [PeriodW-1:0]  cfg_wdata_i   = '0;

  seek_item_t pending_items[$];
  res_t       expected_updates[$];
  seek_item_t drv_item;
  int         drv_wait     = 0;
  int         rx_wait      = 0;
  int         rx_draw;
  bit         rx_fast      = 1'b0;
  bit         hold_kick    = 1'b0;
  int         hold_left    = 0;

  logic [31:0]        acc_us     = '0;
  int                 seek_ang   = 0;
  bit                 sweep_left = 1'b1;
  track_e             cur_track  = TRACK_NONE;
  logic [PeriodW-1:0] cur_period = PERIOD_RESET;
  logic [StepW-1:0]   cur_step   = STEP_RESET;

  int   items_taken  = 0;
  int   results_seen = 0;
  int   fail_count   = 0;
  res_t got_res;
  res_t want_res;
  res_t new_res;

  ir_beacon_servo_seeker_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d updates outstanding", expected_updates.size());
    $display("ir_beacon_servo_seeker_core regression: fail");
    $finish;
  end

  function automatic bit seeker_advance(input logic [ElapsedW-1:0] elapsed,
                                        input logic [ReadingW-1:0] reading,
                                        output res_t r);
    logic [32:0] sum;
    int          ang;
    int          stp;
    sum = {1'b0, acc_us} + 33'(elapsed);
    acc_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    r = '0;
    if (acc_us <= 32'(cur_period)) return 1'b0;
    acc_us = '0;
    stp = int'(cur_step);
    ang = seek_ang;
    case (cur_track)
      TRACK_NONE: begin
        ang = sweep_left ? ang + stp : ang - stp;
        if (!sweep_left && ang < -90) sweep_left = 1'b1;
        if (sweep_left && ang > 90) sweep_left = 1'b0;
      end
      TRACK_LEFT: begin
        ang = ang + stp;
        sweep_left = 1'b1;
      end
      TRACK_RIGHT: begin
        ang = ang - stp;
        sweep_left = 1'b0;
      end
      default: ;
    endcase
    if (ang > 90) ang = 90;
    if (ang < -90) ang = -90;
    seek_ang = ang;
    if (reading == READING_NONE) cur_track = TRACK_NONE;
    else if (reading > READING_CENTER) cur_track = TRACK_LEFT;
    else if (reading < READING_CENTER) cur_track = TRACK_RIGHT;
    else cur_track = TRACK_LOCK;
    r.servo = 8'(((90 - ang) * 255) / 180);
    r.angle = 8'(ang);
    r.track = cur_track;
    return 1'b1;
  endfunction

  function automatic void queue_item(input logic [ElapsedW-1:0] el,
                                     input logic [ReadingW-1:0] rd, input int gp);
    seek_item_t it;
    it.elapsed = el;
    it.reading = rd;
    it.gap     = gp;
    pending_items.push_back(it);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      drv_wait      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (drv_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        drv_wait      <= drv_wait - 1;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        s_axis_tdata  <= {4'd0, drv_item.reading, drv_item.elapsed};
        s_axis_tvalid <= 1'b1;
        drv_wait      <= drv_item.gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_kick) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
      rx_fast       <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 39) == 0) rx_fast <= !rx_fast;
      rx_draw = rx_fast ? 0 : $urandom_range(0, MaxGap);
      m_axis_tready <= (rx_draw == 0);
      rx_wait       <= rx_draw;
    end else if (rx_wait != 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = res_t'(m_axis_tdata[17:0]);
        if (expected_updates.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected update: servo %0d angle %0d track %0d",
                     got_res.servo, got_res.angle, got_res.track);
        end else begin
          want_res = expected_updates.pop_front();
          results_seen++;
          if (got_res.servo !== want_res.servo || got_res.angle !== want_res.angle ||
              got_res.track !== want_res.track) begin
            fail_count++;
            if (fail_count <= 10)
              $display("update %0d: expected servo %0d angle %0d track %0d, got %0d %0d %0d",
                       results_seen, want_res.servo, want_res.angle, want_res.track,
                       got_res.servo, got_res.angle, got_res.track);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_taken++;
        if (seeker_advance(s_axis_tdata[15:0], s_axis_tdata[19:16], new_res))
          expected_updates.push_back(new_res);
      end
    end
  end

  task automatic settle();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_updates.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [PeriodW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_UPDATE_PERIOD) cur_period = val;
    else cur_step = val[StepW-1:0];
  endtask

  task automatic run_phase(input logic [PeriodW-1:0] period, input logic [StepW-1:0] step,
                           input bit with_hold);
    int                  zero_run;
    int                  burst;
    int                  lim;
    int                  gp;
    logic [ElapsedW-1:0] el;
    logic [ReadingW-1:0] rd;
    write_reg(REG_UPDATE_PERIOD, period);
    write_reg(REG_STEP_DEGREES, {14'($urandom), step});
    zero_run = 0;
    burst    = 0;
    lim      = (period > 20'd65535) ? 65535 : int'(period);
    for (int i = 0; i < PhaseItems; i++) begin
      case ($urandom_range(0, 3))
        0: el = 16'($urandom_range(0, 65535));
        1: el = 16'($urandom_range(0, 15));
        2: el = 16'hFFFF;
        default: el = 16'($urandom_range(0, lim));
      endcase
      if (zero_run != 0) begin
        rd = READING_NONE;
        zero_run--;
      end else begin
        if ($urandom_range(0, 7) == 0) zero_run = $urandom_range(5, 40);
        rd = 4'($urandom_range(0, 15));
      end
      if (burst != 0) begin
        gp = 0;
        burst--;
      end else begin
        if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 50);
        gp = $urandom_range(0, MaxGap);
      end
      queue_item(el, rd, with_hold ? 0 : gp);
    end
    if (with_hold) begin
      @(posedge clk_i);
      hold_kick <= 1'b1;
      @(posedge clk_i);
      hold_kick <= 1'b0;
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_item(16'd0, 4'd0, 0);
    queue_item(16'd10000, 4'd0, $urandom_range(0, MaxGap));
    queue_item(16'd1, 4'd7, 0);
    queue_item(16'hFFFF, READING_CENTER, $urandom_range(0, MaxGap));
    queue_item(16'hFFFF, 4'd15, 0);
    queue_item(16'hFFFF, 4'd4, 0);
    queue_item(16'hFFFF, 4'd1, $urandom_range(0, MaxGap));
    queue_item(16'hFFFF, READING_NONE, 0);
    queue_item(16'hFFFF, READING_NONE, 0);
    queue_item(16'hFFFF, 4'd6, $urandom_range(0, MaxGap));
    queue_item(16'hFFFF, 4'd8, 0);
    queue_item(16'hFFFF, 4'd10, 0);
    queue_item(16'hFFFF, 4'd12, $urandom_range(0, MaxGap));
    queue_item(16'hFFFF, 4'd14, 0);
    queue_item(16'hFFFF, 4'd9, 0);
    queue_item(16'hFFFF, 4'd11, $urandom_range(0, MaxGap));
    queue_item(16'hFFFF, 4'd13, 0);
    queue_item(16'hFFFF, 4'd2, 0);
    queue_item(16'hFFFF, 4'd3, $urandom_range(0, MaxGap));
    queue_item(16'h8000, READING_NONE, 0);
    queue_item(16'h5555, READING_NONE, 0);
    queue_item(16'hAAAA, READING_NONE, 0);
    settle();

    run_phase(20'd1, 6'd45, 1'b1);
    run_phase(20'd0, 6'd63, 1'b0);
    run_phase(20'd1000000, 6'd1, 1'b0);
    run_phase(20'hFFFFF, 6'd0, 1'b0);
    run_phase(PERIOD_RESET, STEP_RESET, 1'b0);
    run_phase(20'($urandom_range(1, 100000)), 6'($urandom_range(1, 45)), 1'b0);

    if (expected_updates.size() != 0) begin
      fail_count += expected_updates.size();
      $display("%0d expected updates never arrived", expected_updates.size());
    end
    $display("summary: %0d items accepted, %0d updates checked, %0d mismatches", items_taken,
             results_seen, fail_count);
    $display("covered reset defaults, period 0/1/max, step 0/1/45/63 and a long result stall");
    if (fail_count == 0) begin
      $display("ir_beacon_servo_seeker_core regression: pass");
    end else begin
      $display("ir_beacon_servo_seeker_core regression: fail");
    end
    $finish;
  end

endmodule

>>> ir_beacon_servo_seeker_core.f
+incdir+design
design/ibss_pkg.sv
design/ibss_cfg_regs.sv
design/ibss_update.sv
design/ir_beacon_servo_seeker_core.sv
test/ir_beacon_servo_seeker_core_tb.sv
